### hdl/mspd_pkg.sv
// Package for the MQTT stream packet deframer: parser phase and result kind
// codes, the result record and the register reset value. No dependencies.
package mspd_pkg;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_LEN   = 2'd1,
        PH_BODY  = 2'd2,
        PH_STALL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_BODY      = 2'd1,
        KIND_MALFORMED = 2'd2,
        KIND_OVERSIZE  = 2'd3
    } kind_t;

    localparam int unsigned MAX_W = 29;
    localparam int unsigned LEN_W = 28;
    localparam logic [MAX_W-1:0] MAX_RESET = 29'd1024;

    localparam logic [2:0] ADDR_MAX_PACKET = 3'd0;

    // Number of length bytes after which a set continuation bit is malformed.
    localparam logic [2:0] LEN_BYTES_MAX = 3'd4;

    typedef struct packed {
        kind_t             kind;
        logic [3:0]        packet_type;
        logic [3:0]        packet_flags;
        logic [LEN_W-1:0]  remaining_length;
        logic [7:0]        data_byte;
        logic              last;
    } result_t;

endpackage

### hdl/mqtt_stream_packet_deframer_core.sv
// MQTT 3.1.1 fixed-header deframer: splits a byte stream into header, body and
// error transactions; a result is formed when its byte is taken and then registered.
// Throughput: one byte per cycle unless stalled; parser state updates in the accept cycle.
// A two-entry output stage (result register plus skid register) takes one more result
// while the output is stalled; the input stalls only while the skid entry is full.
// Reset clears all but the output data at once and sets the maximum packet size to 1024.
module mqtt_stream_packet_deframer_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   rx_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   kind,
    output logic [3:0]   packet_type,
    output logic [3:0]   packet_flags,
    output logic [27:0]  remaining_length,
    output logic [7:0]   data_byte,
    output logic         last
);

    logic [mspd_pkg::MAX_W-1:0] max_packet_bytes;
    logic                       byte_fire;
    logic                       res_valid;
    mspd_pkg::result_t          res;

    logic                       out_valid_reg, out_valid_next;
    logic                       skid_valid_reg, skid_valid_next;
    mspd_pkg::result_t          out_data_reg, out_data_next;
    mspd_pkg::result_t          skid_data_reg, skid_data_next;
    logic                       out_take;

    mspd_regs u_regs
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .max_packet_bytes (max_packet_bytes)
    );

    assign in_stall  = skid_valid_reg;
    assign byte_fire = in_valid && !skid_valid_reg;

    mspd_parse u_parse
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_fire        (byte_fire),
        .rx_byte          (rx_byte),
        .max_packet_bytes (max_packet_bytes),
        .res_valid        (res_valid),
        .res              (res)
    );

    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // Input is stalled; drain the skid entry once the output moves.
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid        = out_valid_reg;
    assign kind             = out_data_reg.kind;
    assign packet_type      = out_data_reg.packet_type;
    assign packet_flags     = out_data_reg.packet_flags;
    assign remaining_length = out_data_reg.remaining_length;
    assign data_byte        = out_data_reg.data_byte;
    assign last             = out_data_reg.last;

endmodule

### hdl/mspd_regs.sv
// Configuration register file of the deframer, reached through an APB-style port.
// Depends on mspd_pkg.
module mspd_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [mspd_pkg::MAX_W-1:0]     max_packet_bytes
);

    logic [mspd_pkg::MAX_W-1:0] max_reg;
    logic [mspd_pkg::MAX_W-1:0] max_next;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == mspd_pkg::ADDR_MAX_PACKET);

    always_comb
    begin
        max_next = max_reg;
        if (wr_en)
        begin
            max_next = pwdata[mspd_pkg::MAX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= mspd_pkg::MAX_RESET;
        end
        else
        begin
            max_reg <= max_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == mspd_pkg::ADDR_MAX_PACKET)
        begin
            prdata = {3'd0, max_reg};
        end
    end

    assign max_packet_bytes = max_reg;

endmodule

### hdl/mspd_parse.sv
// Per-byte header parser: tracks the fixed header, the remaining length and the
// body count, and forms at most one result per accepted byte. Depends on mspd_pkg.
module mspd_parse
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_fire,
    input  logic [7:0]                     rx_byte,
    input  logic [mspd_pkg::MAX_W-1:0]     max_packet_bytes,
    output logic                           res_valid,
    output mspd_pkg::result_t              res
);

    mspd_pkg::phase_t               phase_reg, phase_next;
    logic [7:0]                     first_byte_reg, first_byte_next;
    logic [mspd_pkg::LEN_W-1:0]     accum_reg, accum_next;
    logic [2:0]                     count_reg, count_next;
    logic [mspd_pkg::LEN_W-1:0]     body_left_reg, body_left_next;
    logic                           dropping_reg, dropping_next;

    logic [mspd_pkg::LEN_W-1:0]     addend;
    logic [mspd_pkg::LEN_W-1:0]     accum_new;
    logic [2:0]                     count_new;
    logic [mspd_pkg::MAX_W-1:0]     total;
    logic                           is_last;

    // Length groups arrive least significant first, seven bits each.
    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    addend = {21'd0, rx_byte[6:0]};
            2'd1:    addend = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    addend = {7'd0, rx_byte[6:0], 14'd0};
            default: addend = {rx_byte[6:0], 21'd0};
        endcase
    end

    assign accum_new = accum_reg + addend;
    assign count_new = count_reg + 3'd1;
    assign total     = {1'b0, accum_new} + {26'd0, count_new} + 29'd1;
    assign is_last   = (body_left_reg <= 28'd1);

    always_comb
    begin
        phase_next      = phase_reg;
        first_byte_next = first_byte_reg;
        accum_next      = accum_reg;
        count_next      = count_reg;
        body_left_next  = body_left_reg;
        dropping_next   = dropping_reg;
        res_valid       = 1'b0;
        res.kind             = mspd_pkg::KIND_HEADER;
        res.packet_type      = first_byte_reg[7:4];
        res.packet_flags     = first_byte_reg[3:0];
        res.remaining_length = accum_reg;
        res.data_byte        = 8'd0;
        res.last             = 1'b0;

        if (byte_fire)
        begin
            case (phase_reg)
                mspd_pkg::PH_FIRST:
                begin
                    first_byte_next = rx_byte;
                    accum_next      = '0;
                    count_next      = 3'd0;
                    body_left_next  = '0;
                    dropping_next   = 1'b0;
                    phase_next      = mspd_pkg::PH_LEN;
                end
                mspd_pkg::PH_LEN:
                begin
                    accum_next = accum_new;
                    count_next = count_new;
                    res.remaining_length = accum_new;
                    if (rx_byte[7])
                    begin
                        if (count_new >= mspd_pkg::LEN_BYTES_MAX)
                        begin
                            phase_next           = mspd_pkg::PH_STALL;
                            res_valid            = 1'b1;
                            res.kind             = mspd_pkg::KIND_MALFORMED;
                            res.remaining_length = '0;
                        end
                    end
                    else
                    begin
                        body_left_next = accum_new;
                        res_valid      = 1'b1;
                        phase_next     = (accum_new != '0) ? mspd_pkg::PH_BODY
                                                           : mspd_pkg::PH_FIRST;
                        if (total > max_packet_bytes)
                        begin
                            res.kind      = mspd_pkg::KIND_OVERSIZE;
                            dropping_next = (accum_new != '0);
                        end
                        else
                        begin
                            res.kind      = mspd_pkg::KIND_HEADER;
                            res.last      = (accum_new == '0);
                            dropping_next = 1'b0;
                        end
                    end
                end
                mspd_pkg::PH_BODY:
                begin
                    body_left_next = is_last ? '0 : body_left_reg - 28'd1;
                    if (is_last)
                    begin
                        phase_next    = mspd_pkg::PH_FIRST;
                        dropping_next = 1'b0;
                    end
                    if (!dropping_reg)
                    begin
                        res_valid     = 1'b1;
                        res.kind      = mspd_pkg::KIND_BODY;
                        res.data_byte = rx_byte;
                        res.last      = is_last;
                    end
                end
                default:
                begin
                    // A malformed header leaves the parser here until reset.
                    phase_next = mspd_pkg::PH_STALL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mspd_pkg::PH_FIRST;
            first_byte_reg <= 8'd0;
            accum_reg      <= '0;
            count_reg      <= 3'd0;
            body_left_reg  <= '0;
            dropping_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            first_byte_reg <= first_byte_next;
            accum_reg      <= accum_next;
            count_reg      <= count_next;
            body_left_reg  <= body_left_next;
            dropping_reg   <= dropping_next;
        end
    end

endmodule

### hdl/mspd_checker.sv
// Port-level checks for the deframer core, attached to it by the bind below.
// Depends on mspd_pkg and mqtt_stream_packet_deframer_core.
module mspd_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         out_valid,
    input  logic         out_stall,
    input  logic [1:0]   kind,
    input  logic [27:0]  remaining_length,
    input  logic [7:0]   data_byte,
    input  logic         last
);

    // A held transaction stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction withdrawn while stalled");

    // A header flags last exactly when its body is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == mspd_pkg::KIND_HEADER) |-> (last == (remaining_length == 28'd0)))
        else $error("header last flag does not match its length");

    // Error transactions carry neither a last flag nor data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((kind == mspd_pkg::KIND_MALFORMED) || (kind == mspd_pkg::KIND_OVERSIZE))
        |-> (!last && (data_byte == 8'd0)))
        else $error("error transaction carries last or data");

    // No transaction is offered right after a malformed header has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (kind == mspd_pkg::KIND_MALFORMED) |=> !out_valid)
        else $error("transaction emitted after malformed header");

endmodule

bind mqtt_stream_packet_deframer_core mspd_checker u_mspd_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .remaining_length (remaining_length),
    .data_byte        (data_byte),
    .last             (last)
);

### tb/deframe_check.sv
// Watches the register port and both streams of the MQTT deframer, predicts every
// header, body and error transaction from the accepted bytes and compares them in order.
// Depends on mspd_pkg for the phase and kind codes and the result record.
module deframe_check
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [7:0]        rx_byte,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [1:0]        kind,
    input  logic [3:0]        packet_type,
    input  logic [3:0]        packet_flags,
    input  logic [27:0]       remaining_length,
    input  logic [7:0]        data_byte,
    input  logic              last,
    output int                errors,
    output int                pending,
    output int                checked
);
    timeunit 1ns;
    timeprecision 1ps;

    mspd_pkg::phase_t                stage;
    logic [7:0]                      lead_byte;
    logic [mspd_pkg::LEN_W-1:0]      len_sum;
    logic [2:0]                      len_bytes;
    logic [mspd_pkg::LEN_W-1:0]      body_rem;
    logic                            discard;
    logic [mspd_pkg::MAX_W-1:0]      size_limit;
    mspd_pkg::result_t               frames_due[$];

    function automatic mspd_pkg::result_t frame(mspd_pkg::kind_t k,
                                                logic [mspd_pkg::LEN_W-1:0] rl,
                                                logic [7:0] d, logic l);
        mspd_pkg::result_t r;
        r.kind             = k;
        r.packet_type      = lead_byte[7:4];
        r.packet_flags     = lead_byte[3:0];
        r.remaining_length = rl;
        r.data_byte        = d;
        r.last             = l;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mspd_pkg::result_t  got;
        mspd_pkg::result_t  want;
        logic [31:0]        grp;
        logic [31:0]        total;
        logic               fin;
        if (!rst_n)
        begin
            stage      = mspd_pkg::PH_FIRST;
            lead_byte  = '0;
            len_sum    = '0;
            len_bytes  = '0;
            body_rem   = '0;
            discard    = 1'b0;
            size_limit = mspd_pkg::MAX_RESET;
            frames_due.delete();
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == mspd_pkg::ADDR_MAX_PACKET)
                size_limit = pwdata[mspd_pkg::MAX_W-1:0];

            // Results are registered after their bytes, so compare before predicting.
            if (out_valid && !out_stall)
            begin
                got.kind             = mspd_pkg::kind_t'(kind);
                got.packet_type      = packet_type;
                got.packet_flags     = packet_flags;
                got.remaining_length = remaining_length;
                got.data_byte        = data_byte;
                got.last             = last;
                if (frames_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"ERROR: unexpected transaction kind %0d type %h flags %h",
                                  " len %0d data %h last %0b"},
                                 got.kind, got.packet_type, got.packet_flags,
                                 got.remaining_length, got.data_byte, got.last);
                end
                else
                begin
                    want = frames_due.pop_front();
                    checked++;
                    if (got.kind !== want.kind || got.packet_type !== want.packet_type ||
                        got.packet_flags !== want.packet_flags ||
                        got.remaining_length !== want.remaining_length ||
                        got.data_byte !== want.data_byte || got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display({"ERROR: transaction %0d expected kind %0d type %h",
                                      " flags %h len %0d data %h last %0b"},
                                     checked, want.kind, want.packet_type, want.packet_flags,
                                     want.remaining_length, want.data_byte, want.last);
                            $display({"       actual            kind %0d type %h",
                                      " flags %h len %0d data %h last %0b"},
                                     got.kind, got.packet_type, got.packet_flags,
                                     got.remaining_length, got.data_byte, got.last);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                case (stage)
                    mspd_pkg::PH_FIRST:
                    begin
                        lead_byte = rx_byte;
                        len_sum   = '0;
                        len_bytes = '0;
                        body_rem  = '0;
                        discard   = 1'b0;
                        stage     = mspd_pkg::PH_LEN;
                    end
                    mspd_pkg::PH_LEN:
                    begin
                        // Groups are added, not ORed, at seven bits per length byte.
                        grp       = {25'd0, rx_byte[6:0]} << (7 * (len_bytes & 3'd3));
                        len_sum   = len_sum + grp[mspd_pkg::LEN_W-1:0];
                        len_bytes = len_bytes + 3'd1;
                        if (rx_byte[7])
                        begin
                            if (len_bytes >= mspd_pkg::LEN_BYTES_MAX)
                            begin
                                stage = mspd_pkg::PH_STALL;
                                frames_due.push_back(frame(mspd_pkg::KIND_MALFORMED, '0,
                                                           8'h00, 1'b0));
                            end
                        end
                        else
                        begin
                            total    = 32'd1 + len_bytes + len_sum;
                            body_rem = len_sum;
                            fin      = (len_sum == '0);
                            if (total > size_limit)
                            begin
                                frames_due.push_back(frame(mspd_pkg::KIND_OVERSIZE, len_sum,
                                                           8'h00, 1'b0));
                                discard = !fin;
                            end
                            else
                            begin
                                frames_due.push_back(frame(mspd_pkg::KIND_HEADER, len_sum,
                                                           8'h00, fin));
                                discard = 1'b0;
                            end
                            stage = fin ? mspd_pkg::PH_FIRST : mspd_pkg::PH_BODY;
                        end
                    end
                    mspd_pkg::PH_BODY:
                    begin
                        fin      = (body_rem <= 1);
                        body_rem = fin ? '0 : body_rem - 1'b1;
                        if (fin)
                            stage = mspd_pkg::PH_FIRST;
                        if (discard)
                        begin
                            if (fin)
                                discard = 1'b0;
                        end
                        else
                            frames_due.push_back(frame(mspd_pkg::KIND_BODY, len_sum,
                                                       rx_byte, fin));
                    end
                    default:
                    begin
                        // After a malformed length everything is swallowed.
                    end
                endcase
            end
            pending = frames_due.size();
        end
    end

endmodule

### tb/tb_top.sv
// Top of the MQTT deframer testbench: clock, reset, register writes, byte stream
// stimulus, output back-pressure, watchdog and verdict. Depends on mspd_pkg, the
// deframer core and the deframe_check module, which predicts and compares results.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEMS        = 1150;
    localparam int          PARK_CYCLES  = 200;
    localparam int          STALL_LIMIT  = 3000;
    localparam logic [2:0]  ADDR_UNMAPPED = 3'd4;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         in_valid;
    logic         in_stall;
    logic [7:0]   rx_byte;
    logic         out_valid;
    logic         out_stall;
    logic [1:0]   kind;
    logic [3:0]   packet_type;
    logic [3:0]   packet_flags;
    logic [27:0]  remaining_length;
    logic [7:0]   data_byte;
    logic         last;

    int errors;
    int pending;
    int checked;

    int                tx_mode;
    logic              park_req;
    int                bytes_sent;
    int                packets;
    int                settings;

    mqtt_stream_packet_deframer_core dut (.*);

    deframe_check frame_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mode 0 draws a random wait each time, mode 1 never waits, mode 2 waits now and then.
    function automatic int pick_wait(input int mode);
        case (mode)
            0:       return $urandom_range(0, 16);
            1:       return 0;
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays high when the next byte follows.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_wait(tx_mode);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] lead, input int len, input int nlen);
        int          i;
        logic [7:0]  lb;
        logic [27:0] len_v;
        len_v = 28'(len);
        send_byte(lead);
        for (i = 0; i < nlen; i++)
        begin
            lb    = {1'b0, 7'(len_v >> (7 * i))};
            lb[7] = (i != nlen - 1);
            send_byte(lb);
        end
        for (i = 0; i < len; i++)
            send_byte(8'($urandom));
        packets++;
    endtask

    task automatic set_limit(input logic [2:0] addr, input logic [31:0] value);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == mspd_pkg::ADDR_MAX_PACKET)
            settings++;
    endtask

    // Receiver: random stall before each result, plus one long hold-off on request.
    initial
    begin
        int wait_n;
        int served;
        int rx_mode;
        served    = 0;
        rx_mode   = 0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (served % 50 == 0)
                rx_mode = $urandom_range(0, 2);
            if (park_req)
            begin
                park_req  = 1'b0;
                out_stall = 1'b1;
                repeat (PARK_CYCLES) @(negedge clk);
            end
            else
            begin
                wait_n = pick_wait(rx_mode);
                if (wait_n != 0)
                begin
                    out_stall = 1'b1;
                    repeat (wait_n) @(negedge clk);
                end
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
            served++;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int rnd_pkts;
        int len;
        int nlen;
        int shortest;
        int r;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        park_req   = 1'b0;
        tx_mode    = 0;
        bytes_sent = 0;
        packets    = 0;
        settings   = 0;
        rnd_pkts   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: one-byte body behind an all-ones first byte, empty body with a padded four-byte length.
        send_packet(8'hFF, 1, 1);
        send_packet(8'h00, 0, 4);
        // A packet of exactly the limit passes, one byte more is dropped.
        set_limit(mspd_pkg::ADDR_MAX_PACKET, 4);
        send_packet(8'h64, 2, 1);
        send_packet(8'h90, 3, 1);
        // A limit below two drops everything, including empty packets.
        set_limit(mspd_pkg::ADDR_MAX_PACKET, 1);
        send_packet(8'hC0, 0, 1);
        send_packet(8'hE0, 1, 1);
        // Upper data bits are masked; a write to an unmapped address changes nothing.
        set_limit(mspd_pkg::ADDR_MAX_PACKET, 32'hFFFF_FFFF);
        set_limit(ADDR_UNMAPPED, 2);
        send_packet(8'h3B, 1, 1);

        // Hold the output off while a long body streams in back to back.
        set_limit(mspd_pkg::ADDR_MAX_PACKET, 32'(mspd_pkg::MAX_RESET));
        tx_mode  = 1;
        park_req = 1'b1;
        send_packet(8'h35, 90, 1);
        // A two-group length padded to three bytes.
        send_packet(8'h5A, 150, 3);

        while (bytes_sent < ITEMS)
        begin
            if (rnd_pkts % 30 == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    set_limit(ADDR_UNMAPPED, $urandom);
                case ($urandom_range(0, 7))
                    0:       set_limit(mspd_pkg::ADDR_MAX_PACKET, 32'(mspd_pkg::MAX_RESET));
                    1:       set_limit(mspd_pkg::ADDR_MAX_PACKET, 2);
                    2:       set_limit(mspd_pkg::ADDR_MAX_PACKET, 268435460);
                    3:       set_limit(mspd_pkg::ADDR_MAX_PACKET, $urandom_range(0, 1));
                    4:       set_limit(mspd_pkg::ADDR_MAX_PACKET, {3'b111, 29'h1FFF_FFFF});
                    default: set_limit(mspd_pkg::ADDR_MAX_PACKET, $urandom_range(3, 80));
                endcase
            end
            if (rnd_pkts % 8 == 0)
                tx_mode = $urandom_range(0, 2);
            r = $urandom_range(0, 19);
            if (r < 12)
                len = $urandom_range(0, 8);
            else if (r < 18)
                len = $urandom_range(9, 60);
            else if (r == 18)
                len = $urandom_range(61, 300);
            else
                len = $urandom_range(128, 200);
            shortest = (len < 128) ? 1 : 2;
            nlen = shortest;
            if ($urandom_range(0, 3) == 0)
                nlen = $urandom_range(shortest, 4);
            send_packet(8'($urandom), len, nlen);
            rnd_pkts++;
        end

        // A fourth length byte that still continues; the block ignores all that follows.
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        tx_mode = 2;
        send_byte(8'h3C);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h81);
        send_byte(8'h80);
        repeat (3) send_byte(8'($urandom));
        in_valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        $display("Sent %0d stream bytes in %0d packets under %0d size limits; %0d results compared.",
                 bytes_sent, packets, settings, checked);
        $display("Included drops, padded lengths, back-pressure and a malformed length at the end.");
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/mspd_pkg.sv
hdl/mspd_regs.sv
hdl/mspd_parse.sv
hdl/mqtt_stream_packet_deframer_core.sv
hdl/mspd_checker.sv
tb/deframe_check.sv
tb/tb_top.sv
